// ===== sv/ptess_pkg.sv =====
// Shared constants, types and helpers for the path stroke tessellator.
package ptess_pkg;

	localparam int MAX_STEPS = 16;

	// Path commands
	localparam logic [3:0] CMD_CLOSE  = 4'd0;
	localparam logic [3:0] CMD_MOVE   = 4'd1;
	localparam logic [3:0] CMD_LINE   = 4'd2;
	localparam logic [3:0] CMD_HLINE  = 4'd3;
	localparam logic [3:0] CMD_VLINE  = 4'd4;
	localparam logic [3:0] CMD_QUAD   = 4'd5;
	localparam logic [3:0] CMD_CUBIC  = 4'd6;
	localparam logic [3:0] CMD_SCUBIC = 4'd8;

	// Register indexes (paddr[2])
	localparam logic REG_STROKE_WIDTH = 1'b0;
	localparam logic REG_TESS_STEPS   = 1'b1;

	localparam logic [30:0] STROKE_WIDTH_RST = 31'd65536;
	localparam logic [4:0]  TESS_STEPS_RST   = 5'd8;

	// Iteration counts of the serial units
	localparam logic [6:0] DIV_PT_STEPS = 7'd48;
	localparam logic [6:0] DIV_OF_STEPS = 7'd64;
	localparam logic [6:0] SQRT_TOP     = 7'd31;

	// Bias that keeps the curve dividend positive (2^33)
	localparam logic signed [39:0] PT_BIAS = 40'sd8589934592;
	localparam logic signed [39:0] SAT_HI  = 40'sd2147483647;
	localparam logic signed [39:0] SAT_LO  = -40'sd2147483648;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_BAD,
		ST_PT_COEF,
		ST_MUL,
		ST_ACC,
		ST_LOAD,
		ST_DIV,
		ST_DIV_DONE,
		ST_SQRT,
		ST_LEN,
		ST_CH_START,
		ST_NORM,
		ST_EMIT,
		ST_NEXT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		JOB_PT,
		JOB_SQ,
		JOB_OF
	} job_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/path_stroke_tessellator.sv =====
// Path stroke tessellator top level: sequencer and shared arithmetic datapath.
//
// Takes one path segment per transaction and returns the stroke quads it
// causes, four vertices per chord of nonzero length, with last set on the
// final vertex of the segment; a move returns nothing and an unsupported
// command returns one vertex at the origin flagged bad_command. Segment input
// is stalled while a segment is in work. Every step of the work runs on one
// shared 35x32 multiplier, one bit-serial divider and one bit-serial square
// root under a small sequencer. A chord runs the normalizing shift, the
// squares, the square root and two divisions for the offset; each curve
// point adds two divisions plus the Bernstein multiply-accumulate.
// Vertices are emitted through a one-entry holding register and an output
// register, so a stalled result does not stop the arithmetic until both fill.
module path_stroke_tessellator
	import ptess_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  logic [3:0]         kind,
	input  logic               relative,
	input  logic signed [31:0] coord0,
	input  logic signed [31:0] coord1,
	input  logic signed [31:0] coord2,
	input  logic signed [31:0] coord3,
	input  logic signed [31:0] coord4,
	input  logic signed [31:0] coord5,
	output logic               vtx_valid,
	input  logic               vtx_stall,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic               last,
	output logic               bad_command
);

	// Control state
	state_t state_q, state_d;
	logic [30:0] sw_q;
	logic [4:0]  steps_q;
	logic signed [31:0] cur_x_q, cur_y_q, start_x_q, start_y_q;
	logic pend_vld_q, vtx_valid_q;

	// Segment payload and working registers
	logic [3:0] kind_q;
	logic       rel_q;
	logic signed [31:0] c_q [6];
	job_t job_q;
	logic is_curve_q, is_cubic_q;
	logic [4:0]  n_q, k_q;
	logic [12:0] d_q;
	logic [12:0] coef_q [4];
	logic [1:0]  term_q;
	logic        axis_q;
	logic signed [33:0] cp1x_q, cp1y_q;
	logic signed [31:0] cp2x_q, cp2y_q, endx_q, endy_q;
	logic signed [31:0] p0x_q, p0y_q, p1x_q, p1y_q, qx_q;
	logic signed [63:0] prod_q, acc_q;
	logic [63:0] dvd_q, quo_q, sq_v_q, sq_r_q;
	logic [32:0] dvs_q, rem_q;
	logic [6:0]  cnt_q;
	logic [31:0] len_q;
	logic [32:0] mx_q, my_q;
	logic        negx_q, negy_q;
	logic signed [32:0] ox_q, oy_q;
	logic [1:0]  e_idx_q;
	logic signed [31:0] pend_x_q, pend_y_q;
	logic signed [31:0] vx_q, vy_q;
	logic last_q, bad_q;

	// Combinational helpers
	logic [4:0] n_eff, j_val;
	logic signed [31:0] bx, by;
	logic signed [31:0] a0, a1, a2, a3, a4, a5, av;
	logic signed [33:0] pt_sel;
	logic signed [34:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [66:0] mul_p;
	logic signed [63:0] acc_nxt;
	logic        term_last;
	logic [63:0] pt_num;
	logic [33:0] div_r2;
	logic        div_ge;
	logic [63:0] sq_bit, sq_t;
	logic        sq_ge;
	logic signed [31:0] pt_q;
	logic signed [32:0] of_val;
	logic signed [32:0] ch_ex, ch_ey;
	logic [32:0] norm_m;
	logic signed [31:0] vbase_x, vbase_y, vnew_x, vnew_y;
	logic out_free, out_load, pend_load, pend_clr;
	logic signed [31:0] out_x_d, out_y_d;
	logic out_last_d, out_bad_d;
	logic seg_acc;
	logic kind_cubic;

	// APB side
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TESS_STEPS) ? {27'd0, steps_q} : {1'b0, sw_q};

	assign seg_acc = seg_valid && !seg_stall;

	// Clamp the steps register
	always_comb begin
		if (steps_q == 5'd0) begin
			n_eff = 5'd1;
		end else if (steps_q > 5'(MAX_STEPS)) begin
			n_eff = 5'(MAX_STEPS);
		end else begin
			n_eff = steps_q;
		end
	end

	assign kind_cubic = kind_q inside {CMD_CUBIC, CMD_SCUBIC};

	// Relative coordinate sums
	assign bx = rel_q ? cur_x_q : 32'sd0;
	assign by = rel_q ? cur_y_q : 32'sd0;
	assign a0 = sat32(40'(bx) + 40'(c_q[0]));
	assign a1 = sat32(40'(by) + 40'(c_q[1]));
	assign a2 = sat32(40'(bx) + 40'(c_q[2]));
	assign a3 = sat32(40'(by) + 40'(c_q[3]));
	assign a4 = sat32(40'(bx) + 40'(c_q[4]));
	assign a5 = sat32(40'(by) + 40'(c_q[5]));
	assign av = sat32(40'(by) + 40'(c_q[0]));

	assign j_val = n_q - k_q;

	// Select multiplier operands
	always_comb begin
		case (term_q)
			2'd0: pt_sel = axis_q ? 34'(cur_y_q) : 34'(cur_x_q);
			2'd1: pt_sel = axis_q ? cp1y_q : cp1x_q;
			2'd2: begin
				if (is_cubic_q) begin
					pt_sel = axis_q ? 34'(cp2y_q) : 34'(cp2x_q);
				end else begin
					pt_sel = axis_q ? 34'(endy_q) : 34'(endx_q);
				end
			end
			default: pt_sel = axis_q ? 34'(endy_q) : 34'(endx_q);
		endcase
		case (job_q)
			JOB_PT: begin
				mul_a = 35'(pt_sel);
				mul_b = $signed({19'd0, coef_q[term_q]});
			end
			JOB_SQ: begin
				mul_a = term_q[0] ? $signed({4'd0, my_q[30:0]}) : $signed({4'd0, mx_q[30:0]});
				mul_b = term_q[0] ? $signed({1'b0, my_q[30:0]}) : $signed({1'b0, mx_q[30:0]});
			end
			default: begin
				mul_a = $signed({4'd0, sw_q});
				mul_b = axis_q ? $signed({1'b0, my_q[30:0]}) : $signed({1'b0, mx_q[30:0]});
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign acc_nxt = ((term_q == 2'd0) ? 64'sd0 : acc_q) + prod_q;

	always_comb begin
		case (job_q)
			JOB_PT:  term_last = (term_q == (is_cubic_q ? 2'd3 : 2'd2));
			JOB_SQ:  term_last = (term_q == 2'd1);
			default: term_last = (term_q == 2'd0);
		endcase
	end

	// Divider, square root and result shaping
	assign pt_num = 64'(acc_q) + 64'(d_q >> 1) + (64'(d_q) << 33);
	assign div_r2 = {rem_q, dvd_q[63]};
	assign div_ge = (div_r2 >= {1'b0, dvs_q});
	assign sq_bit = 64'd1 << {cnt_q[4:0], 1'b0};
	assign sq_t   = sq_r_q + sq_bit;
	assign sq_ge  = (sq_v_q >= sq_t);
	assign pt_q   = sat32(40'($signed({1'b0, quo_q[35:0]})) - PT_BIAS);
	assign of_val = (axis_q ? negy_q : negx_q) ? -$signed({1'b0, quo_q[31:0]})
	                                           : $signed({1'b0, quo_q[31:0]});

	// Chord normal: the chord edge vector turned a quarter turn
	assign ch_ex  = 33'(p1y_q) - 33'(p0y_q);
	assign ch_ey  = 33'(p0x_q) - 33'(p1x_q);
	assign norm_m = (mx_q > my_q) ? mx_q : my_q;

	// Quad vertex: start or end point, plus or minus the offset
	assign vbase_x = e_idx_q[1] ? p1x_q : p0x_q;
	assign vbase_y = e_idx_q[1] ? p1y_q : p0y_q;
	assign vnew_x  = e_idx_q[0] ? sat32(40'(vbase_x) - 40'(ox_q)) : sat32(40'(vbase_x) + 40'(ox_q));
	assign vnew_y  = e_idx_q[0] ? sat32(40'(vbase_y) - 40'(oy_q)) : sat32(40'(vbase_y) + 40'(oy_q));

	assign out_free = !vtx_valid_q || !vtx_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (seg_valid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				case (kind_q)
					CMD_MOVE: state_d = ST_IDLE;
					CMD_CLOSE, CMD_LINE, CMD_HLINE, CMD_VLINE: state_d = ST_CH_START;
					CMD_QUAD, CMD_CUBIC, CMD_SCUBIC: state_d = ST_PT_COEF;
					default: state_d = ST_BAD;
				endcase
			end
			ST_BAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_PT_COEF: state_d = ST_MUL;
			ST_MUL:     state_d = ST_ACC;
			ST_ACC:     state_d = term_last ? ST_LOAD : ST_MUL;
			ST_LOAD:    state_d = (job_q == JOB_SQ) ? ST_SQRT : ST_DIV;
			ST_DIV: begin
				if (cnt_q == 7'd1) begin
					state_d = ST_DIV_DONE;
				end
			end
			ST_DIV_DONE: begin
				if (!axis_q) begin
					state_d = ST_MUL;
				end else begin
					state_d = (job_q == JOB_PT) ? ST_CH_START : ST_EMIT;
				end
			end
			ST_SQRT: begin
				if (cnt_q == 7'd0) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: state_d = ST_MUL;
			ST_CH_START: begin
				if (p0x_q == p1x_q && p0y_q == p1y_q) begin
					state_d = ST_NEXT;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (!norm_m[32] && !norm_m[31] && norm_m[30]) begin
					state_d = ST_MUL;
				end
			end
			ST_EMIT: begin
				if ((!pend_vld_q || out_free) && e_idx_q == 2'd3) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: state_d = (is_curve_q && k_q < n_q) ? ST_PT_COEF : ST_FINISH;
			ST_FINISH: begin
				if (!pend_vld_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output and handshake controls
	always_comb begin
		seg_stall  = (state_q != ST_IDLE);
		out_load   = 1'b0;
		pend_load  = 1'b0;
		pend_clr   = 1'b0;
		out_x_d    = pend_x_q;
		out_y_d    = pend_y_q;
		out_last_d = 1'b0;
		out_bad_d  = 1'b0;
		case (state_q)
			ST_EMIT: begin
				if (!pend_vld_q || out_free) begin
					out_load  = pend_vld_q;
					pend_load = 1'b1;
				end
			end
			ST_FINISH: begin
				if (pend_vld_q && out_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					pend_clr   = 1'b1;
				end
			end
			ST_BAD: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_x_d    = 32'sd0;
					out_y_d    = 32'sd0;
					out_last_d = 1'b1;
					out_bad_d  = 1'b1;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Control registers, configuration and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sw_q        <= STROKE_WIDTH_RST;
			steps_q     <= TESS_STEPS_RST;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			pend_vld_q  <= 1'b0;
			vtx_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite) begin
				case (paddr[2])
					REG_STROKE_WIDTH: sw_q <= pwdata[30:0];
					REG_TESS_STEPS:   steps_q <= pwdata[4:0];
					default:          sw_q <= sw_q;
				endcase
			end
			if (state_q == ST_SETUP && kind_q == CMD_MOVE) begin
				cur_x_q   <= c_q[0];
				cur_y_q   <= c_q[1];
				start_x_q <= c_q[0];
				start_y_q <= c_q[1];
			end
			if (state_q == ST_FINISH && state_d == ST_IDLE) begin
				cur_x_q <= p1x_q;
				cur_y_q <= p1y_q;
			end
			if (pend_load) begin
				pend_vld_q <= 1'b1;
			end else if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end
			if (out_load) begin
				vtx_valid_q <= 1'b1;
			end else if (!vtx_stall) begin
				vtx_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (seg_acc) begin
			kind_q <= kind;
			rel_q  <= relative;
			c_q[0] <= coord0;
			c_q[1] <= coord1;
			c_q[2] <= coord2;
			c_q[3] <= coord3;
			c_q[4] <= coord4;
			c_q[5] <= coord5;
		end
		if (pend_load) begin
			pend_x_q <= vnew_x;
			pend_y_q <= vnew_y;
		end
		if (out_load) begin
			vx_q   <= out_x_d;
			vy_q   <= out_y_d;
			last_q <= out_last_d;
			bad_q  <= out_bad_d;
		end
		case (state_q)
			ST_SETUP: begin
				p0x_q      <= cur_x_q;
				p0y_q      <= cur_y_q;
				n_q        <= n_eff;
				k_q        <= 5'd1;
				is_curve_q <= kind_q inside {CMD_QUAD, CMD_CUBIC, CMD_SCUBIC};
				is_cubic_q <= kind_cubic;
				d_q        <= kind_cubic ? 13'(n_eff) * 13'(n_eff) * 13'(n_eff)
				                         : 13'(n_eff) * 13'(n_eff);
				case (kind_q)
					CMD_CLOSE: begin
						p1x_q <= start_x_q;
						p1y_q <= start_y_q;
					end
					CMD_LINE: begin
						p1x_q <= a0;
						p1y_q <= a1;
					end
					CMD_HLINE: begin
						p1x_q <= a0;
						p1y_q <= cur_y_q;
					end
					CMD_VLINE: begin
						p1x_q <= cur_x_q;
						p1y_q <= av;
					end
					CMD_QUAD: begin
						cp1x_q <= 34'(a0);
						cp1y_q <= 34'(a1);
						endx_q <= a2;
						endy_q <= a3;
					end
					CMD_CUBIC: begin
						cp1x_q <= 34'(a0);
						cp1y_q <= 34'(a1);
						cp2x_q <= a2;
						cp2y_q <= a3;
						endx_q <= a4;
						endy_q <= a5;
					end
					CMD_SCUBIC: begin
						cp1x_q <= 34'(a0) + 34'(a0) - 34'(a2);
						cp1y_q <= 34'(a1) + 34'(a1) - 34'(a3);
						cp2x_q <= a0;
						cp2y_q <= a1;
						endx_q <= a2;
						endy_q <= a3;
					end
					default: begin
						p1x_q <= p1x_q;
					end
				endcase
			end
			ST_PT_COEF: begin
				// Bernstein weights for t = k/N, scaled by N^2 or N^3
				if (is_cubic_q) begin
					coef_q[0] <= 13'(j_val) * 13'(j_val) * 13'(j_val);
					coef_q[1] <= 13'd3 * 13'(j_val) * 13'(j_val) * 13'(k_q);
					coef_q[2] <= 13'd3 * 13'(j_val) * 13'(k_q) * 13'(k_q);
					coef_q[3] <= 13'(k_q) * 13'(k_q) * 13'(k_q);
				end else begin
					coef_q[0] <= 13'(j_val) * 13'(j_val);
					coef_q[1] <= 13'd2 * 13'(j_val) * 13'(k_q);
					coef_q[2] <= 13'(k_q) * 13'(k_q);
					coef_q[3] <= 13'd0;
				end
				job_q  <= JOB_PT;
				term_q <= 2'd0;
				axis_q <= 1'b0;
			end
			ST_MUL: begin
				prod_q <= mul_p[63:0];
			end
			ST_ACC: begin
				acc_q <= acc_nxt;
				if (!term_last) begin
					term_q <= term_q + 2'd1;
				end
			end
			ST_LOAD: begin
				rem_q <= '0;
				quo_q <= '0;
				case (job_q)
					JOB_PT: begin
						dvd_q <= pt_num << 16;
						dvs_q <= 33'(d_q);
						cnt_q <= DIV_PT_STEPS;
					end
					JOB_SQ: begin
						sq_v_q <= 64'(acc_q);
						sq_r_q <= '0;
						cnt_q  <= SQRT_TOP;
					end
					default: begin
						dvd_q <= 64'(acc_q) + 64'(len_q);
						dvs_q <= {len_q, 1'b0};
						cnt_q <= DIV_OF_STEPS;
					end
				endcase
			end
			ST_DIV: begin
				// Restoring division, one quotient bit per cycle
				rem_q <= div_ge ? 33'(div_r2 - {1'b0, dvs_q}) : div_r2[32:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[62:0], div_ge};
				cnt_q <= cnt_q - 7'd1;
			end
			ST_DIV_DONE: begin
				term_q <= 2'd0;
				axis_q <= 1'b1;
				if (job_q == JOB_PT) begin
					if (!axis_q) begin
						qx_q <= pt_q;
					end else begin
						p1x_q <= qx_q;
						p1y_q <= pt_q;
					end
				end else begin
					if (!axis_q) begin
						ox_q <= of_val;
					end else begin
						oy_q    <= of_val;
						e_idx_q <= 2'd0;
					end
				end
			end
			ST_SQRT: begin
				// One result bit per cycle
				if (sq_ge) begin
					sq_v_q <= sq_v_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				cnt_q <= cnt_q - 7'd1;
			end
			ST_LEN: begin
				len_q  <= sq_r_q[31:0];
				job_q  <= JOB_OF;
				term_q <= 2'd0;
				axis_q <= 1'b0;
			end
			ST_CH_START: begin
				negx_q <= ch_ex < 0;
				negy_q <= ch_ey < 0;
				mx_q   <= (ch_ex < 0) ? 33'(-ch_ex) : 33'(ch_ex);
				my_q   <= (ch_ey < 0) ? 33'(-ch_ey) : 33'(ch_ey);
				job_q  <= JOB_SQ;
				term_q <= 2'd0;
			end
			ST_NORM: begin
				// Shift until the larger magnitude lies in [2^30, 2^31)
				if (norm_m[32] || norm_m[31]) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
				end else if (!norm_m[30]) begin
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
				end
			end
			ST_EMIT: begin
				if (pend_load) begin
					e_idx_q <= e_idx_q + 2'd1;
				end
			end
			ST_NEXT: begin
				p0x_q <= p1x_q;
				p0y_q <= p1y_q;
				if (is_curve_q && k_q < n_q) begin
					k_q <= k_q + 5'd1;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign vtx_valid   = vtx_valid_q;
	assign vertex_x    = vx_q;
	assign vertex_y    = vy_q;
	assign last        = last_q;
	assign bad_command = bad_q;

	// Checks
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid_q && bad_q) |-> last_q)
		else $error("bad command result without last");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_vld_q)
		else $error("held vertex left over at idle");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q != 7'd0))
		else $error("divider ran past its count");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seg_acc |=> (state_q == ST_SETUP))
		else $error("accepted segment not set up");

endmodule
